/* src/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on clk, reset by rst_n.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition implies a property in the following cycle
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* src/pwm_dt_pkg.sv */
// ----------------------------------------------------------------------------
// pwm_dt_pkg
// Types, codes and constants for the three-phase PWM with dead time.
// ----------------------------------------------------------------------------
`default_nettype none

package pwm_dt_pkg;

    localparam int COUNTER_BITS_DEF = 16;
    localparam int DEAD_BITS_DEF    = 7;

    localparam int PERIOD_W   = 16;
    localparam int DEAD_CFG_W = 7;
    localparam int DUTY_W     = 16;
    localparam int SEL_W      = 2;
    localparam int MODE_W     = 2;
    localparam int COUNT_W    = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int NUM_PHASES = 3;

    localparam logic [DUTY_W-1:0]     DUTY_MAX         = 16'd64000;
    localparam logic [PERIOD_W-1:0]   PERIOD_RST       = 16'd3600;
    localparam logic [DEAD_CFG_W-1:0] DEAD_RST         = 7'd72;
    localparam logic [PERIOD_W-1:0]   ADC_SAMPLE_RST   = 16'd64000;
    localparam logic [31:0]           ADC_PROD_RST     = 32'(ADC_SAMPLE_RST) * 32'(PERIOD_RST);
    localparam logic [PERIOD_W-1:0]   ADC_POINT_RST    = ADC_PROD_RST[31:16];

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEAD_TIME  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ADC_SAMPLE = 2'd2;

    typedef enum logic {
        CMD_TICK = 1'b0,
        CMD_SET  = 1'b1
    } cmd_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_OFF  = 2'd0,
        MODE_HIGH = 2'd1,
        MODE_LOW  = 2'd2
    } phase_mode_t;

    // Live configuration handed to the datapath
    typedef struct packed {
        logic [PERIOD_W-1:0]   period;
        logic [DEAD_CFG_W-1:0] dead;
        logic [PERIOD_W-1:0]   adc_point;
    } cfg_t;

    // Per-phase control for one processed transaction
    typedef struct packed {
        logic                tick;
        logic                set;
        phase_mode_t         mode;
        logic [PERIOD_W-1:0] compare;
    } phase_ctl_t;

endpackage

`default_nettype wire

/* src/pwm_dt_cfg.sv */
// ----------------------------------------------------------------------------
// pwm_dt_cfg
// Configuration registers and the registered ADC compare point.
// ----------------------------------------------------------------------------
`default_nettype none

module pwm_dt_cfg
    import pwm_dt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_en,
    input  logic [CFG_IDX_W-1:0]  wr_index,
    input  logic [CFG_DATA_W-1:0] wr_data,
    output cfg_t                  cfg
);

    logic [PERIOD_W-1:0]   period_reg;
    logic [DEAD_CFG_W-1:0] dead_reg;
    logic [PERIOD_W-1:0]   adc_sample_reg;
    logic [PERIOD_W-1:0]   adc_point_reg;
    logic [31:0]           adc_prod;

    // Write the addressed register; drop writes beyond the list
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg     <= PERIOD_RST;
            dead_reg       <= DEAD_RST;
            adc_sample_reg <= ADC_SAMPLE_RST;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_PERIOD:     period_reg     <= wr_data[PERIOD_W-1:0];
                REG_DEAD_TIME:  dead_reg       <= wr_data[DEAD_CFG_W-1:0];
                REG_ADC_SAMPLE: adc_sample_reg <= wr_data[PERIOD_W-1:0];
                default:        ;
            endcase
        end
    end

    // Scale the ADC point by the period, registered after the multiply
    assign adc_prod = 32'(adc_sample_reg) * 32'(period_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            adc_point_reg <= ADC_POINT_RST;
        end
        else
        begin
            adc_point_reg <= adc_prod[31:16];
        end
    end

    assign cfg.period    = period_reg;
    assign cfg.dead      = dead_reg;
    assign cfg.adc_point = adc_point_reg;

endmodule

`default_nettype wire

/* src/pwm_dt_gate.sv */
// ----------------------------------------------------------------------------
// pwm_dt_gate
// Dead-time delay for one gate drive: holds off each rising request.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module pwm_dt_gate
    import pwm_dt_pkg::*;
#(
    parameter int DEAD_BITS = DEAD_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 tick,
    input  logic                 req,
    input  logic [DEAD_BITS-1:0] dead_load,
    output logic                 level
);

    logic [DEAD_BITS-1:0] dead_reg;
    logic [DEAD_BITS-1:0] dead_next;
    logic                 prev_req_reg;
    logic                 prev_req_next;
    logic                 level_reg;
    logic                 level_next;
    logic                 rise_start;

    // Load on a rising request, count down while it holds, clear when it drops
    always_comb
    begin
        dead_next     = dead_reg;
        prev_req_next = prev_req_reg;
        level_next    = level_reg;
        if (tick)
        begin
            priority if (!req)
            begin
                dead_next = '0;
            end
            else if (!prev_req_reg)
            begin
                dead_next = dead_load;
            end
            else if (dead_reg != '0)
            begin
                dead_next = dead_reg - 1'b1;
            end
            else
            begin
                dead_next = '0;
            end
            prev_req_next = req;
            level_next    = req && (dead_next == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dead_reg     <= '0;
            prev_req_reg <= 1'b0;
            level_reg    <= 1'b0;
        end
        else
        begin
            dead_reg     <= dead_next;
            prev_req_reg <= prev_req_next;
            level_reg    <= level_next;
        end
    end

    assign level = level_next;

    // A fresh request with a nonzero dead time
    assign rise_start = tick && req && !prev_req_reg && (dead_load != '0);

    // A driven gate always has a standing request behind it
    `ASSERT_ALWAYS(a_level_has_req, !level_reg || prev_req_reg, "gate driven without request")

    // A fresh request never drives the gate at once unless dead time is zero
    `ASSERT_NEXT(a_rise_waits, rise_start, !level_reg, "rising edge skipped dead time")

endmodule

`default_nettype wire

/* src/pwm_dt_phase.sv */
// ----------------------------------------------------------------------------
// pwm_dt_phase
// One phase: compare and mode store, reference, and two dead-time gates.
// ----------------------------------------------------------------------------
`default_nettype none

module pwm_dt_phase
    import pwm_dt_pkg::*;
#(
    parameter int COUNTER_BITS = COUNTER_BITS_DEF,
    parameter int DEAD_BITS    = DEAD_BITS_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  phase_ctl_t              ctl,
    input  logic [COUNTER_BITS-1:0] count,
    input  logic [DEAD_BITS-1:0]    dead_load,
    output logic                    level_hi,
    output logic                    level_lo
);

    localparam int CW = (COUNTER_BITS > PERIOD_W) ? COUNTER_BITS : PERIOD_W;

    phase_mode_t         mode_reg;
    phase_mode_t         mode_next;
    logic [PERIOD_W-1:0] cmp_reg;
    logic [PERIOD_W-1:0] cmp_next;
    logic                below;
    logic                ref_level;
    logic                active;
    logic                req_hi;
    logic                req_lo;

    // Take a new mode; keep the old compare when going dormant
    always_comb
    begin
        mode_next = mode_reg;
        cmp_next  = cmp_reg;
        if (ctl.set)
        begin
            mode_next = ctl.mode;
            if (ctl.mode != MODE_OFF)
            begin
                cmp_next = ctl.compare;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_OFF;
            cmp_reg  <= '0;
        end
        else
        begin
            mode_reg <= mode_next;
            cmp_reg  <= cmp_next;
        end
    end

    // Form the reference from the new count
    assign below = CW'(count) < CW'(cmp_reg);

    always_comb
    begin
        unique case (mode_reg)
            MODE_HIGH: ref_level = below;
            MODE_LOW:  ref_level = !below;
            default:   ref_level = 1'b0;
        endcase
    end

    assign active = (mode_reg == MODE_HIGH) || (mode_reg == MODE_LOW);
    assign req_hi = active && ref_level;
    assign req_lo = active && !ref_level;

    pwm_dt_gate #(
        .DEAD_BITS (DEAD_BITS)
    ) u_gate_hi (
        .clk       (clk),
        .rst_n     (rst_n),
        .tick      (ctl.tick),
        .req       (req_hi),
        .dead_load (dead_load),
        .level     (level_hi)
    );

    pwm_dt_gate #(
        .DEAD_BITS (DEAD_BITS)
    ) u_gate_lo (
        .clk       (clk),
        .rst_n     (rst_n),
        .tick      (ctl.tick),
        .req       (req_lo),
        .dead_load (dead_load),
        .level     (level_lo)
    );

endmodule

`default_nettype wire

/* src/three_phase_pwm_dead_time.sv */
// ----------------------------------------------------------------------------
// three_phase_pwm_dead_time
// Three-phase complementary PWM with dead time and an ADC trigger.
//
// Channel   Dir  Handshake                     Payload
// s_axis    in   s_axis_tvalid/s_axis_tready   tuser: cmd; tdata: sel, mode, duty
// m_axis    out  m_axis_tvalid/m_axis_tready   tdata: six gates, adc, count
// cfg       in   cfg_valid/cfg_ready           cfg_index, cfg_data
//
// A transaction sits in the input register while the counter, compare and
// dead-time logic work on it, and its result is loaded into the result
// register when the pipeline advances, from where it can be taken. One
// transaction is accepted every cycle while the result register is free or
// being taken. A stalled output holds both stages; the input register
// frees up as soon as the result is taken. Reset clears all timer state at
// once; no sweep follows. cfg_ready is always high.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module three_phase_pwm_dead_time
    import pwm_dt_pkg::*;
#(
    parameter int COUNTER_BITS = COUNTER_BITS_DEF,
    parameter int DEAD_BITS    = DEAD_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [23:0]           s_axis_tdata,  // phase_sel[1:0], phase_mode[3:2], duty[19:4]
    input  logic                  s_axis_tuser,  // cmd
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [23:0]           m_axis_tdata   // high_a, low_a, high_b, low_b, high_c,
                                                 // low_c, adc_trigger, count_value[22:7]
);

    localparam int CW = (COUNTER_BITS > PERIOD_W) ? COUNTER_BITS : PERIOD_W;

    cfg_t                    cfg;
    logic                    in_valid_reg;
    cmd_t                    in_cmd_reg;
    logic [SEL_W-1:0]        in_sel_reg;
    logic [MODE_W-1:0]       in_mode_reg;
    logic [DUTY_W-1:0]       in_duty_reg;
    logic                    out_valid_reg;
    logic [5:0]              out_gate_reg;
    logic                    out_adc_reg;
    logic [COUNT_W-1:0]      out_count_reg;
    logic                    adv;
    logic                    in_accept;
    logic                    is_tick;
    logic                    is_set;
    phase_mode_t             mode_dec;
    logic [DUTY_W-1:0]       duty_clamp;
    logic [31:0]             duty_prod;
    logic [COUNTER_BITS-1:0] counter_reg;
    logic [COUNTER_BITS-1:0] counter_next;
    logic                    adc_hit;
    logic [5:0]              gate_lvl;
    logic [DEAD_BITS-1:0]    dead_load;
    logic                    shoot_through;
    logic                    step_ok;

    pwm_dt_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    assign cfg_ready = 1'b1;

    // Advance the pipeline when the result register is free or being taken
    assign adv           = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || adv;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_cmd_reg  <= cmd_t'(s_axis_tuser);
            in_sel_reg  <= s_axis_tdata[1:0];
            in_mode_reg <= s_axis_tdata[3:2];
            in_duty_reg <= s_axis_tdata[19:4];
        end
    end

    assign is_tick = adv && (in_cmd_reg == CMD_TICK);
    assign is_set  = adv && (in_cmd_reg == CMD_SET);

    // Decode mode; the unused code means dormant
    assign mode_dec = ((in_mode_reg == MODE_HIGH) || (in_mode_reg == MODE_LOW))
                      ? phase_mode_t'(in_mode_reg) : MODE_OFF;

    // Clamp duty and scale by the period
    assign duty_clamp = (in_duty_reg > DUTY_MAX) ? DUTY_MAX : in_duty_reg;
    assign duty_prod  = 32'(duty_clamp) * 32'(cfg.period);

    // Advance the counter: wrap past the period
    always_comb
    begin
        counter_next = counter_reg;
        if (is_tick)
        begin
            if (CW'(counter_reg) >= CW'(cfg.period))
            begin
                counter_next = '0;
            end
            else
            begin
                counter_next = counter_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            counter_reg <= '0;
        end
        else
        begin
            counter_reg <= counter_next;
        end
    end

    assign adc_hit   = is_tick && (CW'(counter_next) == CW'(cfg.adc_point));
    assign dead_load = DEAD_BITS'(cfg.dead);

    // Phase slices
    for (genvar i = 0; i < NUM_PHASES; i++)
    begin : g_phase
        phase_ctl_t ctl;

        assign ctl.tick    = is_tick;
        assign ctl.set     = is_set && (in_sel_reg == SEL_W'(i));
        assign ctl.mode    = mode_dec;
        assign ctl.compare = duty_prod[31:16];

        pwm_dt_phase #(
            .COUNTER_BITS (COUNTER_BITS),
            .DEAD_BITS    (DEAD_BITS)
        ) u_phase (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (ctl),
            .count     (counter_next),
            .dead_load (dead_load),
            .level_hi  (gate_lvl[2*i]),
            .level_lo  (gate_lvl[2*i+1])
        );
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_gate_reg  <= gate_lvl;
            out_adc_reg   <= adc_hit;
            out_count_reg <= COUNT_W'(counter_next);
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_count_reg, out_adc_reg, out_gate_reg};

    // Both gates of one phase on in the held result
    assign shoot_through = (out_gate_reg[0] && out_gate_reg[1])
                        || (out_gate_reg[2] && out_gate_reg[3])
                        || (out_gate_reg[4] && out_gate_reg[5]);

    // Next count is either zero or one above the current count
    assign step_ok = (counter_next == '0)
                  || (counter_next == COUNTER_BITS'(counter_reg + 1'b1));

    // High and low side of a phase are never driven together
    `ASSERT_ALWAYS(a_no_shoot_through, !(out_valid_reg && shoot_through), "both gates driven")

    // A set transaction leaves the counter where it was
    `ASSERT_NEXT(a_set_holds_count, is_set, counter_reg == $past(counter_reg), "count moved")

    // A tick either wraps to zero or steps by one
    `ASSERT_ALWAYS(a_tick_steps, !is_tick || step_ok, "counter skipped a value")

    // The ADC trigger only fires on a tick
    `ASSERT_NEXT(a_adc_on_tick, is_set, !out_adc_reg, "adc trigger on a set")

endmodule

`default_nettype wire
